// ===== rtl/core/priority_interrupt_controller_top_assert.svh =====
// Assertion macros for the RTL; pic_ctrl includes them.
`ifndef PRIORITY_INTERRUPT_CONTROLLER_TOP_ASSERT_SVH
`define PRIORITY_INTERRUPT_CONTROLLER_TOP_ASSERT_SVH

// Same-cycle implication.
`define PIC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define PIC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/pic_pkg.sv =====
package pic_pkg;

  localparam int FILE_BYTES  = 1024;
  localparam int NUM_SOURCES = 16;
  localparam int ADDR_W      = 13;
  localparam int SRC_W       = 4;
  localparam int BYTE_W      = 8;

  localparam logic [1:0] KIND_READ  = 2'd0;
  localparam logic [1:0] KIND_WRITE = 2'd1;
  localparam logic [1:0] KIND_LINE  = 2'd2;

  localparam logic [ADDR_W-1:0] REG_STATUS  = 13'h200;
  localparam logic [ADDR_W-1:0] REG_PEND_HI = 13'h202;
  localparam logic [ADDR_W-1:0] REG_PEND_LO = 13'h203;
  localparam logic [ADDR_W-1:0] REG_ACK10   = 13'h207;

  localparam logic [SRC_W-1:0] ACK_SOURCE = 4'd10;
  localparam int               STATUS_BIT = 7;

  typedef struct packed {
    logic capture;
    logic clr_step;
    logic do_write;
    logic rd_latch;
    logic pend_upd;
    logic scan_step;
    logic fin;
    logic load_out;
  } pic_cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       is_ack;
    logic       clr_last;
    logic       scan_last;
    logic       out_free;
  } pic_sts_t;

endpackage

// ===== rtl/core/pic_ram.sv =====
module pic_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/pic_ctrl.sv =====
module pic_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  pic_pkg::pic_sts_t sts,
  output pic_pkg::pic_cmd_t cmd
);
  import pic_pkg::*;

  localparam logic [2:0] ST_CLR  = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_EXEC = 3'd2;
  localparam logic [2:0] ST_RDW  = 3'd3;
  localparam logic [2:0] ST_SCAN = 3'd4;
  localparam logic [2:0] ST_FIN  = 3'd5;
  localparam logic [2:0] ST_DONE = 3'd6;

  logic [2:0] state_r;
  logic [2:0] state_nxt;
  logic       accept;

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_CLR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_EXEC;
        end
      end
      ST_EXEC: begin
        unique case (sts.kind)
          KIND_READ: state_nxt = ST_RDW;
          KIND_WRITE: begin
            if (sts.is_ack) begin
              cmd.pend_upd = 1'b1;
              state_nxt    = ST_SCAN;
            end else begin
              cmd.do_write = 1'b1;
              state_nxt    = ST_DONE;
            end
          end
          KIND_LINE: begin
            cmd.pend_upd = 1'b1;
            state_nxt    = ST_SCAN;
          end
          default: state_nxt = ST_DONE;
        endcase
      end
      ST_RDW: begin
        cmd.rd_latch = 1'b1;
        state_nxt    = ST_DONE;
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_last) state_nxt = ST_FIN;
      end
      ST_FIN: begin
        cmd.fin   = 1'b1;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

`include "priority_interrupt_controller_top_assert.svh"

  `PIC_ASSERT_NXT(a_accept_exec, accept, state_r == ST_EXEC, "accepted beat did not start")
  `PIC_ASSERT_NXT(a_scan_fin, (state_r == ST_SCAN) && sts.scan_last, state_r == ST_FIN,
                  "scan did not end after last source")
  `PIC_ASSERT_IMP(a_load_free, cmd.load_out, sts.out_free, "result loaded over a held beat")
  `PIC_ASSERT_IMP(a_clr_stall, state_r == ST_CLR, in_stall, "input taken during clear")

endmodule

// ===== rtl/core/pic_dp.sv =====
module pic_dp #(
  parameter int FILE_BYTES = pic_pkg::FILE_BYTES
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [1:0]                      in_kind,
  input  logic [pic_pkg::ADDR_W-1:0]      in_address,
  input  logic [pic_pkg::BYTE_W-1:0]      in_write_data,
  input  logic [pic_pkg::SRC_W-1:0]       in_source,
  input  logic                            in_line_level,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [pic_pkg::BYTE_W-1:0]      out_read_data,
  output logic [pic_pkg::BYTE_W-1:0]      out_cpu_level,
  output logic                            out_level_changed,
  input  pic_pkg::pic_cmd_t               cmd,
  output pic_pkg::pic_sts_t               sts
);
  import pic_pkg::*;

  localparam int AW = $clog2(FILE_BYTES);

  logic [1:0]              kind_r;
  logic [ADDR_W-1:0]       addr_r;
  logic [BYTE_W-1:0]       wdata_r;
  logic [SRC_W-1:0]        src_r;
  logic                    lvl_r;
  logic [NUM_SOURCES-1:0]  pend_r;
  logic [BYTE_W-1:0]       status_r;
  logic [BYTE_W-1:0]       active_r;
  logic [BYTE_W-1:0]       best_r;
  logic [SRC_W-1:0]        scan_cnt_r;
  logic                    cmp_vld_r;
  logic [SRC_W-1:0]        cmp_idx_r;
  logic [AW-1:0]           clr_cnt_r;
  logic [BYTE_W-1:0]       res_rd_r;
  logic                    chg_r;
  logic                    out_valid_r;
  logic [BYTE_W-1:0]       out_rd_r;
  logic [BYTE_W-1:0]       out_lvl_r;
  logic                    out_chg_r;

  logic                    in_file;
  logic                    is_status;
  logic                    is_pend_hi;
  logic                    is_pend_lo;
  logic [SRC_W-1:0]        lc_src;
  logic                    lc_lvl;
  logic [BYTE_W-1:0]       cand;
  logic [BYTE_W-1:0]       rd_val;
  logic                    ram_we;
  logic [AW-1:0]           ram_waddr;
  logic [BYTE_W-1:0]       ram_wdata;
  logic [AW-1:0]           ram_raddr;
  logic [BYTE_W-1:0]       ram_rdata;

  assign in_file    = addr_r < ADDR_W'(FILE_BYTES);
  assign is_status  = (addr_r == REG_STATUS);
  assign is_pend_hi = (addr_r == REG_PEND_HI);
  assign is_pend_lo = (addr_r == REG_PEND_LO);

  assign lc_src = (kind_r == KIND_WRITE) ? ACK_SOURCE : src_r;
  assign lc_lvl = (kind_r == KIND_WRITE) ? 1'b0 : lvl_r;

  assign cand = (cmp_vld_r && pend_r[cmp_idx_r] && (ram_rdata > best_r)) ? ram_rdata : best_r;

  always_comb begin
    if (!in_file)        rd_val = '0;
    else if (is_status)  rd_val = status_r;
    else if (is_pend_hi) rd_val = pend_r[15:8];
    else if (is_pend_lo) rd_val = pend_r[7:0];
    else                 rd_val = ram_rdata;
  end

  assign ram_we    = cmd.clr_step ||
                     (cmd.do_write && in_file && !is_status && !is_pend_hi && !is_pend_lo);
  assign ram_waddr = cmd.clr_step ? clr_cnt_r : addr_r[AW-1:0];
  assign ram_wdata = cmd.clr_step ? '0 : wdata_r;
  assign ram_raddr = cmd.scan_step ? AW'(scan_cnt_r) : addr_r[AW-1:0];

  pic_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (FILE_BYTES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_r  <= in_kind;
      addr_r  <= in_address;
      wdata_r <= in_write_data;
      src_r   <= in_source;
      lvl_r   <= in_line_level;
    end
    if (cmd.capture)       res_rd_r <= '0;
    else if (cmd.rd_latch) res_rd_r <= rd_val;
    if (cmd.capture)       chg_r <= 1'b0;
    else if (cmd.pend_upd) chg_r <= 1'b1;
    if (cmd.pend_upd) begin
      best_r     <= '0;
      scan_cnt_r <= '0;
      cmp_idx_r  <= '0;
    end else if (cmd.scan_step) begin
      best_r     <= cand;
      scan_cnt_r <= scan_cnt_r + 1'b1;
      cmp_idx_r  <= scan_cnt_r;
    end
    if (cmd.load_out) begin
      out_rd_r  <= res_rd_r;
      out_lvl_r <= active_r;
      out_chg_r <= chg_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= '0;
      status_r    <= '0;
      active_r    <= '0;
      clr_cnt_r   <= '0;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clr_step) clr_cnt_r <= clr_cnt_r + 1'b1;
      if (cmd.pend_upd)       cmp_vld_r <= 1'b0;
      else if (cmd.scan_step) cmp_vld_r <= 1'b1;
      if (cmd.pend_upd) begin
        pend_r[lc_src] <= lc_lvl;
      end else if (cmd.do_write && is_pend_hi) begin
        pend_r[15:8] <= wdata_r;
      end else if (cmd.do_write && is_pend_lo) begin
        pend_r[7:0] <= wdata_r;
      end
      if (cmd.do_write && is_status) begin
        status_r <= wdata_r;
      end else if (cmd.fin) begin
        if (cand != '0)          status_r[STATUS_BIT] <= 1'b1;
        else if (active_r != '0) status_r[STATUS_BIT] <= 1'b0;
      end
      if (cmd.fin) active_r <= cand;
      if (cmd.load_out)  out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  assign sts.kind      = kind_r;
  assign sts.is_ack    = (addr_r == REG_ACK10);
  assign sts.clr_last  = (clr_cnt_r == AW'(FILE_BYTES - 1));
  assign sts.scan_last = (scan_cnt_r == SRC_W'(NUM_SOURCES - 1));
  assign sts.out_free  = !out_valid_r || !out_stall;

  assign out_valid         = out_valid_r;
  assign out_read_data     = out_rd_r;
  assign out_cpu_level     = out_lvl_r;
  assign out_level_changed = out_chg_r;

endmodule

// ===== rtl/core/priority_interrupt_controller_top.sv =====
// Channel  Direction  Handshake           Payload
// in_      input      in_valid/in_stall   kind, address, write_data, source, line_level
// out_     output     out_valid/out_stall kind-specific result: read_data, cpu_level,
//                                         level_changed
// Reads, stores and kind 3 complete without a scan; a line change or a write at 0x207
// runs a scan of the 16 level bytes through the single RAM read port.
// After reset a clearing pass zeroes the 1024-byte file while in_stall is high.
// A finished result sits in an output register; the next beat is taken while it waits,
// and that beat completes once the output register frees.
module priority_interrupt_controller_top #(
  parameter int FILE_BYTES = pic_pkg::FILE_BYTES
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  in_kind,
  input  logic [pic_pkg::ADDR_W-1:0]  in_address,
  input  logic [pic_pkg::BYTE_W-1:0]  in_write_data,
  input  logic [pic_pkg::SRC_W-1:0]   in_source,
  input  logic                        in_line_level,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [pic_pkg::BYTE_W-1:0]  out_read_data,
  output logic [pic_pkg::BYTE_W-1:0]  out_cpu_level,
  output logic                        out_level_changed
);
  import pic_pkg::*;

  pic_cmd_t cmd;
  pic_sts_t sts;

  pic_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  pic_dp #(
    .FILE_BYTES (FILE_BYTES)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_kind           (in_kind),
    .in_address        (in_address),
    .in_write_data     (in_write_data),
    .in_source         (in_source),
    .in_line_level     (in_line_level),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_read_data     (out_read_data),
    .out_cpu_level     (out_cpu_level),
    .out_level_changed (out_level_changed),
    .cmd               (cmd),
    .sts               (sts)
  );

endmodule
